>>> rtl/core/rpld_pkg.sv
// Package for the run-length palette line decoder.
// Holds field widths, register codes, reset values, shared structs and the grey table.
// No dependencies.
package rpld_pkg;

    // Field widths
    localparam int unsigned CNT_W      = 10;
    localparam int unsigned COLOR_W    = 16;
    localparam int unsigned LINE_W     = 16;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Largest line the decoder supports; the effective width is clamped to it
    localparam int unsigned MAX_LINE_WIDTH = 1023;
    localparam int unsigned CNT_MAX        = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] WIDTH_LIMIT =
        (MAX_LINE_WIDTH < CNT_MAX) ? CNT_W'(MAX_LINE_WIDTH) : CNT_W'(CNT_MAX);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(CNT_MAX);

    // Register reset values
    localparam logic [CNT_W-1:0]   LINE_WIDTH_RST = 10'd320;
    localparam logic [COLOR_W-1:0] PAD_COLOR_RST  = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 2'd0,
        CFG_PAD_COLOR  = 2'd1
    } cfg_index_t;

    // Input command codes
    typedef enum logic {
        CMD_CODE = 1'b0,
        CMD_PAD  = 1'b1
    } command_t;

    typedef struct packed {
        logic [CNT_W-1:0]   line_width;
        logic [COLOR_W-1:0] pad_color;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  pixel_position;
        logic [CNT_W-1:0]  bytes_in_line;
        logic [LINE_W-1:0] line_counter;
    } line_state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [CNT_W-1:0]   run_count;
        logic               line_end;
        logic [CNT_W-1:0]   line_byte_count;
        logic [LINE_W-1:0]  line_number;
    } result_t;

    // Fixed 16-level RGB565 grey palette
    function automatic logic [COLOR_W-1:0] grey_level(input logic [3:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            4'd0:    c = 16'h0000;
            4'd1:    c = 16'h1082;
            4'd2:    c = 16'h2104;
            4'd3:    c = 16'h3186;
            4'd4:    c = 16'h4228;
            4'd5:    c = 16'h52AA;
            4'd6:    c = 16'h632C;
            4'd7:    c = 16'h73AE;
            4'd8:    c = 16'h8C51;
            4'd9:    c = 16'h9CD3;
            4'd10:   c = 16'hAD55;
            4'd11:   c = 16'hBDD7;
            4'd12:   c = 16'hCE79;
            4'd13:   c = 16'hDE7B;
            4'd14:   c = 16'hEF7D;
            default: c = 16'hFFFF;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/rpld_cfg_regs.sv
// Configuration registers of the line decoder: line width and pad color.
// Depends on rpld_pkg.
module rpld_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rpld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpld_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rpld_pkg::cfg_t                     cfg
);

    logic [rpld_pkg::CNT_W-1:0]   line_width_reg;
    logic [rpld_pkg::COLOR_W-1:0] pad_color_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register file; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= rpld_pkg::LINE_WIDTH_RST;
            pad_color_reg  <= rpld_pkg::PAD_COLOR_RST;
        end else if (cfg_valid) begin
            case (rpld_pkg::cfg_index_t'(cfg_index))
                rpld_pkg::CFG_LINE_WIDTH: line_width_reg <= cfg_data[rpld_pkg::CNT_W-1:0];
                rpld_pkg::CFG_PAD_COLOR:  pad_color_reg  <= cfg_data[rpld_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = {line_width_reg, pad_color_reg};

endmodule

>>> rtl/core/rpld_decode.sv
// Run decode logic: palette lookup, truncation at line end, line bookkeeping.
// Purely combinational; depends on rpld_pkg.
module rpld_decode (
    input  rpld_pkg::cfg_t                  cfg,
    input  rpld_pkg::line_state_t           state,
    input  logic                            command,
    input  logic [rpld_pkg::CODE_W-1:0]     code_byte,
    output rpld_pkg::result_t               result,
    output rpld_pkg::line_state_t           state_next
);

    logic [rpld_pkg::CNT_W-1:0]   width_act;
    logic [rpld_pkg::CNT_W-1:0]   remaining;
    logic [rpld_pkg::CNT_W-1:0]   run_len;
    logic [rpld_pkg::CNT_W-1:0]   count;
    logic [rpld_pkg::CNT_W-1:0]   bytes;
    logic [rpld_pkg::COLOR_W-1:0] color;
    logic                         end_of_line;

    // Effective width: zero reads as one, clamp to the supported maximum
    always_comb begin
        width_act = cfg.line_width;
        if (width_act == '0) begin
            width_act = rpld_pkg::CNT_W'(1);
        end
        if (width_act > rpld_pkg::WIDTH_LIMIT) begin
            width_act = rpld_pkg::WIDTH_LIMIT;
        end
    end

    // Pixels left in the line; zero when the width was lowered to or below the current position
    assign remaining = (state.pixel_position >= width_act) ?
                       '0 : (width_act - state.pixel_position);

    assign run_len = rpld_pkg::CNT_W'({1'b0, code_byte[7:4]}) + rpld_pkg::CNT_W'(1);

    // Run selection
    always_comb begin
        if (rpld_pkg::command_t'(command) == rpld_pkg::CMD_PAD) begin
            color       = cfg.pad_color;
            count       = remaining;
            bytes       = state.bytes_in_line;
            end_of_line = 1'b1;
        end else begin
            color       = rpld_pkg::grey_level(code_byte[3:0]);
            count       = (run_len < remaining) ? run_len : remaining;
            bytes       = (state.bytes_in_line == rpld_pkg::CNT_SAT) ?
                          rpld_pkg::CNT_SAT : state.bytes_in_line + rpld_pkg::CNT_W'(1);
            end_of_line = (count == remaining);
        end
    end

    // Result fields; line totals only on a completed line
    always_comb begin
        result.pixel_color     = color;
        result.run_count       = count;
        result.line_end        = end_of_line;
        result.line_byte_count = end_of_line ? bytes : '0;
        result.line_number     = end_of_line ? state.line_counter : '0;
    end

    // Line state update
    always_comb begin
        if (end_of_line) begin
            state_next.pixel_position = '0;
            state_next.bytes_in_line  = '0;
            state_next.line_counter   = state.line_counter + rpld_pkg::LINE_W'(1);
        end else begin
            state_next.pixel_position = state.pixel_position + count;
            state_next.bytes_in_line  = bytes;
            state_next.line_counter   = state.line_counter;
        end
    end

endmodule

>>> rtl/core/rle_palette_line_decoder_top.sv
// Top level of the run-length palette line decoder.
// Uses rpld_pkg, rpld_cfg_regs and rpld_decode.
//
// Usage:
//   Input channel s_*: one item per code byte (s_command = 0) or pad command
//   (s_command = 1). Result channel m_*: one run per input item, a color and
//   a pixel count; m_line_end marks the run that completes a line, and then
//   m_line_byte_count and m_line_number report the line's code bytes and index.
//   Config channel cfg_*: index 0 is the line width, index 1 the pad color;
//   always ready, write only while no items are in flight.
//   Path: an accepted item goes through the input register and decode into the
//   result register, which raises m_valid; a stalled result register holds it back.
//   Throughput: one item per cycle while the receiver takes results, set by the single
//   decode stage whose line state updates in the same cycle it fires.
//   Reset (aresetn low, synchronous) empties both registers, clears the pixel
//   position, byte count and line counter, and loads width 320 and pad white.
//   A stalled receiver holds the result register; the input register keeps
//   one more item, after which s_ready drops until m_ready returns.
module rle_palette_line_decoder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [rpld_pkg::CODE_W-1:0]         s_code_byte,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rpld_pkg::COLOR_W-1:0]        m_pixel_color,
    output logic [rpld_pkg::CNT_W-1:0]          m_run_count,
    output logic                                m_line_end,
    output logic [rpld_pkg::CNT_W-1:0]          m_line_byte_count,
    output logic [rpld_pkg::LINE_W-1:0]         m_line_number,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpld_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rpld_pkg::cfg_t        cfg;
    rpld_pkg::line_state_t state_reg;
    rpld_pkg::line_state_t state_next;
    rpld_pkg::result_t     result_next;
    rpld_pkg::result_t     result_reg;

    logic                          in_valid_reg;
    logic                          in_command_reg;
    logic [rpld_pkg::CODE_W-1:0]   in_code_reg;
    logic                          out_valid_reg;
    logic                          advance;
    logic                          s_fire;

    rpld_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpld_decode u_decode (
        .cfg        (cfg),
        .state      (state_reg),
        .command    (in_command_reg),
        .code_byte  (in_code_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    // Handshake: decode fires when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload register
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_command_reg <= s_command;
            in_code_reg    <= s_code_byte;
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pixel_color     = result_reg.pixel_color;
    assign m_run_count       = result_reg.run_count;
    assign m_line_end        = result_reg.line_end;
    assign m_line_byte_count = result_reg.line_byte_count;
    assign m_line_number     = result_reg.line_number;

endmodule

>>> rtl/core/rpld_checker.sv
// Port-level checks for the line decoder, bound to the top level.
// Depends on rpld_pkg and rle_palette_line_decoder_top.
module rpld_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [rpld_pkg::COLOR_W-1:0]        m_pixel_color,
    input logic [rpld_pkg::CNT_W-1:0]          m_run_count,
    input logic                                m_line_end,
    input logic [rpld_pkg::CNT_W-1:0]          m_line_byte_count,
    input logic [rpld_pkg::LINE_W-1:0]         m_line_number
);

    // A stalled run holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_color) && $stable(m_run_count)
            && $stable(m_line_end))
        else $error("result changed while stalled");

    // Line totals are zero unless the run closes the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_line_end |-> m_line_byte_count == '0 && m_line_number == '0)
        else $error("line totals on an open line");

    // A run that leaves the line open always has pixels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_line_end |-> m_run_count != '0)
        else $error("empty run on an open line");

    // Only a pad can give more than sixteen pixels, and a pad ends the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_count > rpld_pkg::CNT_W'(16) |-> m_line_end)
        else $error("long run without line end");

endmodule

bind rle_palette_line_decoder_top rpld_checker u_rpld_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_pixel_color     (m_pixel_color),
    .m_run_count       (m_run_count),
    .m_line_end        (m_line_end),
    .m_line_byte_count (m_line_byte_count),
    .m_line_number     (m_line_number)
);

>>> tb/tb_top.sv
// Self-checking testbench for rle_palette_line_decoder_top: drives code bytes and pad
// commands, predicts every pixel run in step with the accepted items and checks each result.
// Depends on rpld_pkg and the decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_AT     = 1300;
    localparam int unsigned HOLD_LEN    = 250;
    localparam int unsigned PRINT_CAP   = 30;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    typedef struct {
        rpld_pkg::command_t              cmd;
        logic [rpld_pkg::CODE_W-1:0]     code;
    } code_item_t;

    // DUT ports
    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic                             s_command = 1'b0;
    logic [rpld_pkg::CODE_W-1:0]      s_code_byte = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [rpld_pkg::COLOR_W-1:0]     m_pixel_color;
    logic [rpld_pkg::CNT_W-1:0]       m_run_count;
    logic                             m_line_end;
    logic [rpld_pkg::CNT_W-1:0]       m_line_byte_count;
    logic [rpld_pkg::LINE_W-1:0]      m_line_number;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [rpld_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [rpld_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor copy of the registers and the line state
    logic [rpld_pkg::CNT_W-1:0]       width_reg = rpld_pkg::LINE_WIDTH_RST;
    logic [rpld_pkg::COLOR_W-1:0]     pad_reg = rpld_pkg::PAD_COLOR_RST;
    logic [rpld_pkg::CNT_W-1:0]       pix_pos = '0;
    logic [rpld_pkg::CNT_W-1:0]       byte_tally = '0;
    logic [rpld_pkg::LINE_W-1:0]      line_idx = '0;

    logic [rpld_pkg::COLOR_W-1:0] grey_shades [16] = '{
        16'h0000, 16'h1082, 16'h2104, 16'h3186,
        16'h4228, 16'h52AA, 16'h632C, 16'h73AE,
        16'h8C51, 16'h9CD3, 16'hAD55, 16'hBDD7,
        16'hCE79, 16'hDE7B, 16'hEF7D, 16'hFFFF
    };

    code_item_t            items_to_send[$];
    rpld_pkg::result_t     runs_due[$];

    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned pads_accepted = 0;
    int unsigned lines_seen = 0;
    int unsigned empty_runs = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Idling knobs, set per phase
    int unsigned gap_max = 0;
    sink_mode_t  sink_mode = SINK_ALWAYS;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic [2:0]  stall_phase = '0;

    rle_palette_line_decoder_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_code_byte       (s_code_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_color     (m_pixel_color),
        .m_run_count       (m_run_count),
        .m_line_end        (m_line_end),
        .m_line_byte_count (m_line_byte_count),
        .m_line_number     (m_line_number),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("%0t mismatch on %s: got %0h, want %0h (result %0d)",
                     $realtime, what, got, want, results_seen);
        end
    endtask

    // Expected run for one accepted item; advances the line state
    function automatic void predict_run(input rpld_pkg::command_t cmd,
                                        input logic [rpld_pkg::CODE_W-1:0] code);
        rpld_pkg::result_t r;
        int unsigned w;
        int unsigned room;
        int unsigned run_len;
        int unsigned cnt;
        int unsigned nbytes;
        w = 32'(width_reg);
        if (w == 0) w = 1;
        if (w > rpld_pkg::MAX_LINE_WIDTH) w = rpld_pkg::MAX_LINE_WIDTH;
        room = (32'(pix_pos) >= w) ? 0 : w - 32'(pix_pos);
        if (cmd == rpld_pkg::CMD_PAD) begin
            r.pixel_color = pad_reg;
            cnt           = room;
            nbytes        = 32'(byte_tally);
            r.line_end    = 1'b1;
        end else begin
            run_len       = 32'(code[7:4]) + 1;
            r.pixel_color = grey_shades[code[3:0]];
            cnt           = (run_len < room) ? run_len : room;
            nbytes        = 32'(byte_tally) + 1;
            if (nbytes > rpld_pkg::CNT_MAX) nbytes = rpld_pkg::CNT_MAX;
            r.line_end    = (cnt == room);
        end
        r.run_count = rpld_pkg::CNT_W'(cnt);
        if (r.line_end) begin
            r.line_byte_count = rpld_pkg::CNT_W'(nbytes);
            r.line_number     = line_idx;
            pix_pos           = '0;
            byte_tally        = '0;
            line_idx          = line_idx + rpld_pkg::LINE_W'(1);
        end else begin
            r.line_byte_count = '0;
            r.line_number     = '0;
            pix_pos           = pix_pos + rpld_pkg::CNT_W'(cnt);
            byte_tally        = rpld_pkg::CNT_W'(nbytes);
        end
        runs_due.push_back(r);
    endfunction

    // Input driver: bursts of items separated by random gaps, none when gap_max is zero
    always @(posedge aclk) begin
        code_item_t nxt;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_command   <= rpld_pkg::CMD_CODE;
            s_code_byte <= '0;
            gap_left    <= 0;
            burst_left  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_run(rpld_pkg::command_t'(s_command), s_code_byte);
                items_accepted++;
                if (s_command == rpld_pkg::CMD_PAD) pads_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    nxt = items_to_send.pop_front();
                    s_valid     <= 1'b1;
                    s_command   <= nxt.cmd;
                    s_code_byte <= nxt.code;
                    if (burst_left != 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once the run is well under way
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin
        rpld_pkg::result_t want;
        logic    rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (runs_due.size() == 0) begin
                    report_mismatch("unexpected result, color", m_pixel_color, 0);
                end else begin
                    want = runs_due.pop_front();
                    if (m_pixel_color !== want.pixel_color)
                        report_mismatch("pixel_color", m_pixel_color, want.pixel_color);
                    if (m_run_count !== want.run_count)
                        report_mismatch("run_count", m_run_count, want.run_count);
                    if (m_line_end !== want.line_end)
                        report_mismatch("line_end", m_line_end, want.line_end);
                    if (m_line_byte_count !== want.line_byte_count)
                        report_mismatch("line_byte_count", m_line_byte_count,
                                        want.line_byte_count);
                    if (m_line_number !== want.line_number)
                        report_mismatch("line_number", m_line_number, want.line_number);
                end
                if (m_line_end === 1'b1) lines_seen++;
                if (m_run_count == 0) empty_runs++;
            end
            stall_phase <= stall_phase + 1'b1;
            case (sink_mode)
                SINK_ALWAYS: rdy = 1'b1;
                SINK_RANDOM: rdy = ($urandom_range(0, 99) < 65);
                default:     rdy = (stall_phase < 3'd5);
            endcase
            m_ready <= rdy && (hold_left == 0);
        end
    end

    // Run timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d runs still due", cycle_count,
                     runs_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_item(input rpld_pkg::command_t cmd,
                              input logic [rpld_pkg::CODE_W-1:0] code);
        code_item_t it;
        it.cmd  = cmd;
        it.code = code;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    // Every item yields one run, so the block is idle once all runs are back
    task automatic wait_idle();
        while (results_seen < items_queued) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input rpld_pkg::cfg_index_t idx,
                             input logic [rpld_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == rpld_pkg::CFG_LINE_WIDTH) width_reg = data[rpld_pkg::CNT_W-1:0];
        else pad_reg = data;
        reg_writes++;
    endtask

    // Stimulus
    initial begin
        int unsigned w;
        logic [rpld_pkg::COLOR_W-1:0] pad;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: all field extremes, a trailing pad and a blank line
        gap_max   = 2;
        sink_mode = SINK_RANDOM;
        queue_item(rpld_pkg::CMD_CODE, 8'h00);
        queue_item(rpld_pkg::CMD_CODE, 8'hFF);
        queue_item(rpld_pkg::CMD_CODE, 8'hF0);
        queue_item(rpld_pkg::CMD_CODE, 8'h0F);
        queue_item(rpld_pkg::CMD_CODE, 8'hA5);
        queue_item(rpld_pkg::CMD_CODE, 8'h5A);
        queue_item(rpld_pkg::CMD_PAD, 8'h00);
        queue_item(rpld_pkg::CMD_PAD, 8'hFF);
        wait_idle();

        // Zero width acts as one pixel
        write_reg(rpld_pkg::CFG_LINE_WIDTH, 16'd0);
        write_reg(rpld_pkg::CFG_PAD_COLOR, 16'h0000);
        queue_item(rpld_pkg::CMD_CODE, 8'h30);
        queue_item(rpld_pkg::CMD_PAD, 8'hC3);
        wait_idle();

        // Widest line
        write_reg(rpld_pkg::CFG_LINE_WIDTH, 16'd1023);
        write_reg(rpld_pkg::CFG_PAD_COLOR, 16'hA5C3);
        queue_item(rpld_pkg::CMD_CODE, 8'h7E);
        queue_item(rpld_pkg::CMD_CODE, 8'h81);
        queue_item(rpld_pkg::CMD_PAD, 8'h3C);
        wait_idle();

        // Width lowered below the current position, then a code byte
        write_reg(rpld_pkg::CFG_LINE_WIDTH, 16'd40);
        queue_item(rpld_pkg::CMD_CODE, 8'hF3);
        queue_item(rpld_pkg::CMD_CODE, 8'hF3);
        wait_idle();
        write_reg(rpld_pkg::CFG_LINE_WIDTH, 16'd20);
        queue_item(rpld_pkg::CMD_CODE, 8'h11);
        queue_item(rpld_pkg::CMD_CODE, 8'hF3);
        queue_item(rpld_pkg::CMD_CODE, 8'hF3);
        wait_idle();

        // Width lowered exactly to the current position, then a pad
        write_reg(rpld_pkg::CFG_LINE_WIDTH, 16'd40);
        queue_item(rpld_pkg::CMD_CODE, 8'hF1);
        queue_item(rpld_pkg::CMD_CODE, 8'hF1);
        wait_idle();
        write_reg(rpld_pkg::CFG_LINE_WIDTH, 16'd32);
        queue_item(rpld_pkg::CMD_PAD, 8'h96);
        wait_idle();

        // One full-width line of single-pixel runs, no idling on either side
        write_reg(rpld_pkg::CFG_LINE_WIDTH, 16'd1023);
        write_reg(rpld_pkg::CFG_PAD_COLOR, 16'($urandom));
        gap_max   = 0;
        sink_mode = SINK_ALWAYS;
        for (int i = 0; i < 1023; i++) queue_item(rpld_pkg::CMD_CODE, {4'h0, 4'($urandom)});
        wait_idle();

        // Random phases over a spread of widths; line state carries across them
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       w = $urandom_range(2, 24);
                1:       w = 1;
                2:       w = $urandom_range(25, 200);
                3:       w = 1023;
                4:       w = $urandom_range(2, 24);
                5:       w = $urandom_range(1, 1023);
                6:       w = $urandom_range(2, 64);
                default: w = 0;
            endcase
            pad = (ph == 1) ? 16'hFFFF : (ph == 7) ? 16'h0000 : 16'($urandom);
            write_reg(rpld_pkg::CFG_LINE_WIDTH, rpld_pkg::CFG_DATA_W'(w));
            write_reg(rpld_pkg::CFG_PAD_COLOR, pad);
            sink_mode = sink_mode_t'(ph % 3);
            gap_max   = (ph % 4 == 2) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 9) == 0) queue_item(rpld_pkg::CMD_PAD, 8'($urandom));
                else queue_item(rpld_pkg::CMD_CODE, 8'($urandom));
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (runs_due.size() != 0) report_mismatch("runs left over", runs_due.size(), 0);
        $display("covered %0d items (%0d pads), %0d lines done, %0d zero-length runs",
                 items_accepted, pads_accepted, lines_seen, empty_runs);
        $display("%0d register writes, widths from 0 to 1023, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
